// File: rtl/i2cmbe_pkg.sv
// Package for the I2C master byte engine: payload structs, command codes,
// the classified command type and reset constants. No dependencies.
package i2cmbe_pkg;

  // Command codes carried in the op field
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Configuration register indexes (word address)
  localparam logic REG_UNIT_TICKS = 1'b0;
  localparam logic REG_ACK_LIMIT  = 1'b1;

  localparam logic [15:0] UNIT_TICKS_RST = 16'd100;
  localparam logic [7:0]  ACK_LIMIT_RST  = 8'd250;
  localparam logic [7:0]  MSB_MASK       = 8'h80;

  localparam int DELAY_W       = 18;
  localparam int QUEUE_DEPTH_D = 4;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;
  } out_item_t;

  // Classified tick handed from the front to the back
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_item_t;

endpackage

// File: rtl/i2cmbe_front.sv
// Front of the I2C master byte engine: accepts input ticks, decodes op into
// a command class and holds the result until the queue takes it. Uses i2cmbe_pkg.
module i2cmbe_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  i2cmbe_pkg::in_item_t   in_data,
  input  logic                   q_full,
  output logic                   q_push,
  output i2cmbe_pkg::tick_item_t q_data
);

  logic                   valid_r;
  logic                   valid_nxt;
  i2cmbe_pkg::tick_item_t item_r;
  i2cmbe_pkg::cmd_t       cmd_dec;
  logic                   take;

  always_comb begin
    case (in_data.op)
      i2cmbe_pkg::OP_START: cmd_dec = i2cmbe_pkg::CMD_START;
      i2cmbe_pkg::OP_STOP:  cmd_dec = i2cmbe_pkg::CMD_STOP;
      i2cmbe_pkg::OP_WRITE: cmd_dec = i2cmbe_pkg::CMD_WRITE;
      i2cmbe_pkg::OP_READ:  cmd_dec = i2cmbe_pkg::CMD_READ;
      default:              cmd_dec = i2cmbe_pkg::CMD_NONE;
    endcase
  end

  assign in_stall  = valid_r && q_full;
  assign take      = in_valid && !in_stall;
  assign q_push    = valid_r && !q_full;
  assign q_data    = item_r;
  assign valid_nxt = take || (valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      item_r.cmd      <= cmd_dec;
      item_r.tx_byte  <= in_data.tx_byte;
      item_r.send_ack <= in_data.send_ack;
      item_r.sda_in   <= in_data.sda_in;
    end
  end

endmodule

// File: rtl/i2cmbe_queue.sv
// Short FIFO between the front and back of the I2C master byte engine.
// Holds classified ticks; uses i2cmbe_pkg for the entry type.
module i2cmbe_queue #(
  parameter int DEPTH = i2cmbe_pkg::QUEUE_DEPTH_D
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  i2cmbe_pkg::tick_item_t wr_data,
  output logic                   full,
  input  logic                   pop,
  output logic                   empty,
  output i2cmbe_pkg::tick_item_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  i2cmbe_pkg::tick_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count above depth");

  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> !full)
    else $error("queue still full after pop");

endmodule

// File: rtl/i2cmbe_back.sv
// Back of the I2C master byte engine: bus sequencer stepped once per tick,
// plus the result register. Uses i2cmbe_pkg for types and constants.
module i2cmbe_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  i2cmbe_pkg::tick_item_t q_data,
  input  logic [15:0]            unit_ticks,
  input  logic [7:0]             ack_poll_limit,
  output logic                   out_valid,
  input  logic                   out_stall,
  output i2cmbe_pkg::out_item_t  out_data
);

  localparam int DW = i2cmbe_pkg::DELAY_W;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_SP_A,
    PH_SP_B,
    PH_WR_SET,
    PH_WR_HI,
    PH_WR_LO,
    PH_AK_REL,
    PH_AK_HI,
    PH_AK_POLL,
    PH_RD_LO,
    PH_RD_HI,
    PH_RA_LO,
    PH_RA_HI
  } phase_t;

  phase_t    phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [3:0] bit_cnt_inc;
  logic [7:0] shift_r, shift_nxt;
  logic [DW-1:0] delay_r, delay_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_choice_r, ack_choice_nxt;
  logic       nack_r, nack_nxt;
  logic       done;
  logic [7:0] rx;
  logic [DW-1:0] dly1, dly2, dly4;

  logic                  out_valid_r;
  i2cmbe_pkg::out_item_t out_data_r;
  logic                  step;

  assign step      = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop     = step;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign dly1        = DW'(unit_ticks);
  assign dly2        = dly1 << 1;
  assign dly4        = dly1 << 2;
  assign bit_cnt_inc = bit_cnt_r + 4'd1;

  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    delay_nxt      = delay_r;
    poll_nxt       = poll_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_choice_nxt = ack_choice_r;
    nack_nxt       = nack_r;
    done           = 1'b0;
    rx             = 8'd0;
    if (phase_r == PH_IDLE) begin
      case (q_data.cmd)
        i2cmbe_pkg::CMD_START: begin
          sda_nxt = 1'b1; scl_nxt = 1'b1;
          phase_nxt = PH_ST_A; delay_nxt = dly4;
        end
        i2cmbe_pkg::CMD_STOP: begin
          scl_nxt = 1'b0; sda_nxt = 1'b0;
          phase_nxt = PH_SP_A; delay_nxt = dly4;
        end
        i2cmbe_pkg::CMD_WRITE: begin
          nack_nxt = 1'b0; scl_nxt = 1'b0; bit_cnt_nxt = 4'd0;
          sda_nxt = |(q_data.tx_byte & i2cmbe_pkg::MSB_MASK);
          shift_nxt = {q_data.tx_byte[6:0], 1'b0};
          phase_nxt = PH_WR_SET; delay_nxt = dly2;
        end
        i2cmbe_pkg::CMD_READ: begin
          sda_nxt = 1'b1; scl_nxt = 1'b0; shift_nxt = 8'd0; bit_cnt_nxt = 4'd0;
          ack_choice_nxt = q_data.send_ack;
          phase_nxt = PH_RD_LO; delay_nxt = dly2;
        end
        default: ;
      endcase
    end else if (delay_r > DW'(1)) begin
      delay_nxt = delay_r - 1'b1;
    end else begin
      case (phase_r)
        PH_ST_A: begin
          sda_nxt = 1'b0; phase_nxt = PH_ST_B; delay_nxt = dly4;
        end
        PH_ST_B: begin
          scl_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1;
        end
        PH_SP_A: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = PH_SP_B; delay_nxt = dly4;
        end
        PH_SP_B: begin
          phase_nxt = PH_IDLE; done = 1'b1;
        end
        PH_WR_SET: begin
          scl_nxt = 1'b1; phase_nxt = PH_WR_HI; delay_nxt = dly2;
        end
        PH_WR_HI: begin
          scl_nxt = 1'b0; phase_nxt = PH_WR_LO; delay_nxt = dly2;
        end
        PH_WR_LO: begin
          bit_cnt_nxt = bit_cnt_inc;
          if (bit_cnt_inc >= 4'd8) begin
            sda_nxt = 1'b1; poll_nxt = 8'd0;
            phase_nxt = PH_AK_REL; delay_nxt = dly1;
          end else begin
            sda_nxt = |(shift_r & i2cmbe_pkg::MSB_MASK);
            shift_nxt = {shift_r[6:0], 1'b0};
            phase_nxt = PH_WR_SET; delay_nxt = dly2;
          end
        end
        PH_AK_REL: begin
          scl_nxt = 1'b1; phase_nxt = PH_AK_HI; delay_nxt = dly1;
        end
        PH_AK_HI, PH_AK_POLL: begin
          if (!q_data.sda_in) begin
            scl_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1;
          end else if (poll_r >= ack_poll_limit) begin
            // timeout: flag and run a stop
            nack_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0;
            phase_nxt = PH_SP_A; delay_nxt = dly4;
          end else begin
            poll_nxt = poll_r + 8'd1;
            phase_nxt = PH_AK_POLL; delay_nxt = dly1;
          end
        end
        PH_RD_LO: begin
          scl_nxt = 1'b1;
          shift_nxt = {shift_r[6:0], q_data.sda_in};
          bit_cnt_nxt = bit_cnt_inc;
          phase_nxt = PH_RD_HI; delay_nxt = dly1;
        end
        PH_RD_HI: begin
          scl_nxt = 1'b0;
          if (bit_cnt_r >= 4'd8) begin
            sda_nxt = !ack_choice_r; phase_nxt = PH_RA_LO; delay_nxt = dly2;
          end else begin
            phase_nxt = PH_RD_LO; delay_nxt = dly2;
          end
        end
        PH_RA_LO: begin
          scl_nxt = 1'b1; phase_nxt = PH_RA_HI; delay_nxt = dly2;
        end
        PH_RA_HI: begin
          scl_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1; rx = shift_r;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_cnt_r    <= 4'd0;
      shift_r      <= 8'd0;
      delay_r      <= '0;
      poll_r       <= 8'd0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ack_choice_r <= 1'b0;
      nack_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (step) begin
        phase_r      <= phase_nxt;
        bit_cnt_r    <= bit_cnt_nxt;
        shift_r      <= shift_nxt;
        delay_r      <= delay_nxt;
        poll_r       <= poll_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        ack_choice_r <= ack_choice_nxt;
        nack_r       <= nack_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
    if (step) begin
      out_data_r.scl_out   <= scl_nxt;
      out_data_r.sda_out   <= sda_nxt;
      out_data_r.ready_res <= (phase_nxt == PH_IDLE);
      out_data_r.done_res  <= done;
      out_data_r.rx_byte   <= rx;
      out_data_r.nack      <= nack_nxt;
    end
  end

  a_hold_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r != PH_IDLE && delay_r > DW'(1)) |=> phase_r == $past(phase_r))
    else $error("phase changed while delay still running");

  a_rx_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.rx_byte != 8'd0) |-> out_data_r.done_res)
    else $error("received byte shown without done");

  a_bit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'd8)
    else $error("bit count past eight");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.done_res) |-> out_data_r.ready_res)
    else $error("done without return to idle");

endmodule

// File: rtl/i2c_master_byte_engine_unit.sv
// I2C master byte engine, top level. Ties the front, queue and back
// together and holds the APB configuration registers. Uses i2cmbe_pkg.
//
// Usage: each transaction on the input channel (in_valid/in_stall/in_data)
// is one bus tick: a command (start, stop, write byte, read byte, or none)
// plus the sampled SDA level. Commands are taken only while the sequencer
// is idle; while busy, op is ignored but sda_in is still used. Every input
// transaction yields exactly one result on the output channel
// (out_valid/out_stall/out_data) with SCL/SDA drive levels, ready, done,
// the received byte and the NACK flag.
// Throughput is one tick per cycle while out_stall is low; an accepted
// tick passes the front register, the queue, then the sequencer step into
// the result register. The sequencer step is the loop that sets this rate.
// When out_stall is high the result register holds; the queue absorbs up
// to QUEUE_DEPTH ticks plus one in the front register before in_stall rises.
// Reset (rst_n low, synchronous) idles the sequencer with both lines
// released, empties the queue and loads unit_ticks = 100 and
// ack_poll_limit = 250. Write the registers only while the engine is idle.
module i2c_master_byte_engine_unit #(
  parameter int QUEUE_DEPTH = i2cmbe_pkg::QUEUE_DEPTH_D
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cmbe_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cmbe_pkg::out_item_t out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [15:0]            unit_ticks_r;
  logic [7:0]             ack_limit_r;
  logic                   cfg_wr;
  logic                   q_push, q_full, q_pop, q_empty;
  i2cmbe_pkg::tick_item_t q_wr_data, q_rd_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      i2cmbe_pkg::REG_UNIT_TICKS: cfg_prdata = {16'd0, unit_ticks_r};
      i2cmbe_pkg::REG_ACK_LIMIT:  cfg_prdata = {24'd0, ack_limit_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= i2cmbe_pkg::UNIT_TICKS_RST;
      ack_limit_r  <= i2cmbe_pkg::ACK_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        i2cmbe_pkg::REG_UNIT_TICKS: unit_ticks_r <= cfg_pwdata[15:0];
        i2cmbe_pkg::REG_ACK_LIMIT:  ack_limit_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  i2cmbe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  i2cmbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  i2cmbe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_data         (q_rd_data),
    .unit_ticks     (unit_ticks_r),
    .ack_poll_limit (ack_limit_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

// File: bench/tb_i2c_byte_pkg.sv
`timescale 1ns / 1ps
// Bus-phase prediction and result checking for the I2C master byte engine bench.
// Depends on i2cmbe_pkg for the payload structs, command codes and MSB mask.
package tb_i2c_byte_pkg;

  typedef enum logic [3:0] {
    BP_IDLE,
    BP_START_A,
    BP_START_B,
    BP_STOP_A,
    BP_STOP_B,
    BP_WR_SET,
    BP_WR_HI,
    BP_WR_LO,
    BP_ACK_REL,
    BP_ACK_HI,
    BP_ACK_POLL,
    BP_RD_LO,
    BP_RD_HI,
    BP_RA_LO,
    BP_RA_HI
  } bus_phase_t;

  class i2c_byte_scoreboard;
    logic [15:0]            unit_ticks;
    logic [7:0]             poll_limit;
    bus_phase_t             phase;
    logic [3:0]             bit_cnt;
    logic [7:0]             shifter;
    logic [17:0]            delay_cnt;
    logic [7:0]             polls;
    logic                   scl_lvl;
    logic                   sda_lvl;
    logic                   ack_sel;
    logic                   nack_flg;
    i2cmbe_pkg::out_item_t  line_states_due[$];
    int                     errors;

    function new();
      unit_ticks = i2cmbe_pkg::UNIT_TICKS_RST;
      poll_limit = i2cmbe_pkg::ACK_LIMIT_RST;
      phase      = BP_IDLE;
      bit_cnt    = '0;
      shifter    = '0;
      delay_cnt  = '0;
      polls      = '0;
      scl_lvl    = 1'b1;
      sda_lvl    = 1'b1;
      ack_sel    = 1'b0;
      nack_flg   = 1'b0;
      errors     = 0;
    endfunction

    // Load the hold time of the phase being entered, truncated to the counter width
    function void enter(bus_phase_t nxt, int unsigned units);
      logic [31:0] prod;
      prod      = units * unit_ticks;
      phase     = nxt;
      delay_cnt = prod[17:0];
    endfunction

    // Advance the sequencer by one accepted tick and queue the line state it produces
    function void predict_tick(i2cmbe_pkg::in_item_t it);
      i2cmbe_pkg::out_item_t want;
      logic                  done_now;
      logic [7:0]            rx_now;
      done_now = 1'b0;
      rx_now   = '0;
      if (phase == BP_IDLE) begin
        case (it.op)
          i2cmbe_pkg::OP_START: begin
            sda_lvl = 1'b1;
            scl_lvl = 1'b1;
            enter(BP_START_A, 4);
          end
          i2cmbe_pkg::OP_STOP: begin
            scl_lvl = 1'b0;
            sda_lvl = 1'b0;
            enter(BP_STOP_A, 4);
          end
          i2cmbe_pkg::OP_WRITE: begin
            nack_flg = 1'b0;
            scl_lvl  = 1'b0;
            bit_cnt  = '0;
            sda_lvl  = |(it.tx_byte & i2cmbe_pkg::MSB_MASK);
            shifter  = {it.tx_byte[6:0], 1'b0};
            enter(BP_WR_SET, 2);
          end
          i2cmbe_pkg::OP_READ: begin
            sda_lvl = 1'b1;
            scl_lvl = 1'b0;
            shifter = '0;
            bit_cnt = '0;
            ack_sel = it.send_ack;
            enter(BP_RD_LO, 2);
          end
          default: ;
        endcase
      end else if (delay_cnt > 18'd1) begin
        delay_cnt = delay_cnt - 18'd1;
      end else begin
        case (phase)
          BP_START_A: begin
            sda_lvl = 1'b0;
            enter(BP_START_B, 4);
          end
          BP_START_B: begin
            scl_lvl  = 1'b0;
            phase    = BP_IDLE;
            done_now = 1'b1;
          end
          BP_STOP_A: begin
            scl_lvl = 1'b1;
            sda_lvl = 1'b1;
            enter(BP_STOP_B, 4);
          end
          BP_STOP_B: begin
            phase    = BP_IDLE;
            done_now = 1'b1;
          end
          BP_WR_SET: begin
            scl_lvl = 1'b1;
            enter(BP_WR_HI, 2);
          end
          BP_WR_HI: begin
            scl_lvl = 1'b0;
            enter(BP_WR_LO, 2);
          end
          BP_WR_LO: begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
              sda_lvl = 1'b1;
              polls   = '0;
              enter(BP_ACK_REL, 1);
            end else begin
              sda_lvl = |(shifter & i2cmbe_pkg::MSB_MASK);
              shifter = {shifter[6:0], 1'b0};
              enter(BP_WR_SET, 2);
            end
          end
          BP_ACK_REL: begin
            scl_lvl = 1'b1;
            enter(BP_ACK_HI, 1);
          end
          BP_ACK_HI, BP_ACK_POLL: begin
            if (!it.sda_in) begin
              scl_lvl  = 1'b0;
              phase    = BP_IDLE;
              done_now = 1'b1;
            end else if (polls >= poll_limit) begin
              // out of polls: run the stop and flag the missing ACK
              nack_flg = 1'b1;
              scl_lvl  = 1'b0;
              sda_lvl  = 1'b0;
              enter(BP_STOP_A, 4);
            end else begin
              polls = polls + 8'd1;
              enter(BP_ACK_POLL, 1);
            end
          end
          BP_RD_LO: begin
            scl_lvl = 1'b1;
            shifter = {shifter[6:0], it.sda_in};
            bit_cnt = bit_cnt + 4'd1;
            enter(BP_RD_HI, 1);
          end
          BP_RD_HI: begin
            scl_lvl = 1'b0;
            if (bit_cnt >= 4'd8) begin
              sda_lvl = ~ack_sel;
              enter(BP_RA_LO, 2);
            end else begin
              enter(BP_RD_LO, 2);
            end
          end
          BP_RA_LO: begin
            scl_lvl = 1'b1;
            enter(BP_RA_HI, 2);
          end
          BP_RA_HI: begin
            scl_lvl  = 1'b0;
            phase    = BP_IDLE;
            done_now = 1'b1;
            rx_now   = shifter;
          end
          default: phase = BP_IDLE;
        endcase
      end
      want.scl_out   = scl_lvl;
      want.sda_out   = sda_lvl;
      want.ready_res = (phase == BP_IDLE);
      want.done_res  = done_now;
      want.rx_byte   = rx_now;
      want.nack      = nack_flg;
      line_states_due.push_back(want);
    endfunction

    function void flag(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_line_state(i2cmbe_pkg::out_item_t got);
      i2cmbe_pkg::out_item_t want;
      if (line_states_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = line_states_due.pop_front();
      flag("scl_out", want.scl_out, got.scl_out);
      flag("sda_out", want.sda_out, got.sda_out);
      flag("ready_res", want.ready_res, got.ready_res);
      flag("done_res", want.done_res, got.done_res);
      flag("rx_byte", want.rx_byte, got.rx_byte);
      flag("nack", want.nack, got.nack);
    endfunction
  endclass

endpackage

// File: bench/tb_i2c_master_byte_engine_unit.sv
`timescale 1ns / 1ps
// Top-level bench for i2c_master_byte_engine_unit: drives bus ticks and APB writes,
// checks every result against tb_i2c_byte_pkg. Depends on i2cmbe_pkg and the RTL.
module tb_i2c_master_byte_engine_unit;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  i2cmbe_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  i2cmbe_pkg::out_item_t out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [2:0]            cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  bit calm           = 1'b0;
  int ack_after      = 0;
  int rd_level       = 2;
  int frame_left     = -1;
  int cmd_count      = 0;
  bit addr_due       = 1'b0;
  bit last_was_write = 1'b0;

  tb_i2c_byte_pkg::i2c_byte_scoreboard sb;

  i2c_master_byte_engine_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Check with the stall value of this edge, then pick the next one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_line_state(out_data);
    out_stall <= !calm && ($urandom_range(99) < 14);
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [2:0] addr, input logic [31:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== want) begin
      sb.errors++;
      $display("%0t: register read at %0d mismatch, expected %h, actual %h", $time,
               addr, want, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] ticks, input logic [7:0] limit);
    cfg_write({i2cmbe_pkg::REG_UNIT_TICKS, 2'b00}, {16'd0, ticks});
    cfg_write({i2cmbe_pkg::REG_ACK_LIMIT, 2'b00}, {24'd0, limit});
    sb.unit_ticks = ticks;
    sb.poll_limit = limit;
  endtask

  task automatic send_tick(input i2cmbe_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_tick(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.line_states_due.size() != 0) @(posedge clk);
  endtask

  // SDA level for the next tick: follow the ACK plan on the deciding poll, the read level when set, else random
  function automatic logic pick_sda();
    if ((sb.phase == tb_i2c_byte_pkg::BP_ACK_HI || sb.phase == tb_i2c_byte_pkg::BP_ACK_POLL)
        && sb.delay_cnt <= 18'd1)
      return !(ack_after >= 0 && sb.polls >= ack_after);
    if (sb.phase == tb_i2c_byte_pkg::BP_RD_LO && rd_level != 2) return rd_level[0];
    return 1'($urandom_range(1));
  endfunction

  // Next command of a host frame: start, address write, data bytes, stop
  function automatic logic [2:0] frame_op();
    logic [2:0] op;
    if (sb.nack_flg && last_was_write) frame_left = -1;
    if (frame_left < 0) begin
      op         = i2cmbe_pkg::OP_START;
      frame_left = $urandom_range(2, 5);
      addr_due   = 1'b1;
    end else if (frame_left == 0) begin
      op         = i2cmbe_pkg::OP_STOP;
      frame_left = -1;
    end else begin
      op         = (addr_due || $urandom_range(1)) ? i2cmbe_pkg::OP_WRITE
                                                    : i2cmbe_pkg::OP_READ;
      addr_due   = 1'b0;
      frame_left--;
    end
    return op;
  endfunction

  task automatic random_tick();
    i2cmbe_pkg::in_item_t it;
    it.op       = 3'($urandom_range(7));
    it.tx_byte  = 8'($urandom);
    it.send_ack = 1'($urandom_range(1));
    it.sda_in   = pick_sda();
    if (sb.phase == tb_i2c_byte_pkg::BP_IDLE) begin
      if ($urandom_range(99) >= 12) it.op = frame_op();
      if (it.op inside {[i2cmbe_pkg::OP_START:i2cmbe_pkg::OP_READ]}) begin
        cmd_count++;
        last_was_write = (it.op == i2cmbe_pkg::OP_WRITE);
        if (it.op == i2cmbe_pkg::OP_WRITE) begin
          if ($urandom_range(3) == 0) ack_after = -1;
          else ack_after = $urandom_range(5);
        end
      end
    end
    send_tick(it);
  endtask

  task automatic finish_command();
    while (sb.phase != tb_i2c_byte_pkg::BP_IDLE) random_tick();
  endtask

  task automatic end_phase();
    finish_command();
    wait_drained();
  endtask

  task automatic issue(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                       input int plan, input int rdl);
    i2cmbe_pkg::in_item_t it;
    ack_after   = plan;
    rd_level    = rdl;
    it.op       = op;
    it.tx_byte  = tx;
    it.send_ack = ack;
    it.sda_in   = 1'($urandom_range(1));
    send_tick(it);
    finish_command();
    rd_level = 2;
  endtask

  task automatic run_random(input int n, input int hold_at);
    cmd_count = 0;
    while (cmd_count < n) begin
      random_tick();
      if (cmd_count == hold_at) begin
        wait_drained();
        hold_at = -1;
      end
    end
  endtask

  initial begin
    i2cmbe_pkg::in_item_t wide_it;
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, then idle ticks at the reset timing
    cfg_read_check({i2cmbe_pkg::REG_UNIT_TICKS, 2'b00}, {16'd0, i2cmbe_pkg::UNIT_TICKS_RST});
    cfg_read_check({i2cmbe_pkg::REG_ACK_LIMIT, 2'b00}, {24'd0, i2cmbe_pkg::ACK_LIMIT_RST});
    issue(i2cmbe_pkg::OP_NONE, 8'h00, 1'b0, 0, 2);
    issue(3'd5, 8'hFF, 1'b1, 0, 2);
    issue(i2cmbe_pkg::OP_NONE, 8'hA5, 1'b1, 0, 2);
    issue(3'd7, 8'h00, 1'b0, 0, 2);
    end_phase();

    // zero unit and zero poll limit
    set_config(16'd0, 8'd0);
    issue(i2cmbe_pkg::OP_START, 8'h00, 1'b0, 0, 2);
    issue(i2cmbe_pkg::OP_WRITE, 8'hFF, 1'b0, 0, 2);
    issue(i2cmbe_pkg::OP_WRITE, 8'h00, 1'b1, -1, 2);
    issue(i2cmbe_pkg::OP_WRITE, 8'h80, 1'b0, 1, 2);
    issue(i2cmbe_pkg::OP_READ, 8'h00, 1'b1, 0, 1);
    issue(i2cmbe_pkg::OP_READ, 8'hFF, 1'b0, 0, 0);
    issue(i2cmbe_pkg::OP_READ, 8'h5A, 1'b1, 0, 2);
    issue(3'd5, 8'hFF, 1'b1, 0, 2);
    issue(3'd6, 8'h00, 1'b0, 0, 2);
    issue(3'd7, 8'hFF, 1'b1, 0, 2);
    issue(i2cmbe_pkg::OP_NONE, 8'h00, 1'b0, 0, 2);
    issue(i2cmbe_pkg::OP_STOP, 8'h00, 1'b0, 0, 2);
    end_phase();

    // poll limit of one: ACK on the last allowed poll, then one poll late
    set_config(16'd0, 8'd1);
    issue(i2cmbe_pkg::OP_WRITE, 8'h01, 1'b0, 1, 2);
    issue(i2cmbe_pkg::OP_WRITE, 8'h7F, 1'b1, 2, 2);
    issue(i2cmbe_pkg::OP_WRITE, 8'h55, 1'b0, -1, 2);
    end_phase();

    // long stretch with no idling on either side
    calm = 1'b1;
    set_config(16'd1, 8'd2);
    issue(i2cmbe_pkg::OP_WRITE, 8'hC3, 1'b0, 1, 2);
    issue(i2cmbe_pkg::OP_READ, 8'h3C, 1'b0, 0, 2);
    end_phase();
    calm = 1'b0;

    set_config(16'd1, 8'd1);
    run_random(3, 1);
    end_phase();

    set_config(16'd0, 8'd3);
    run_random(4, -1);
    end_phase();

    // widest unit: the hold time fills the delay counter
    set_config(16'd65535, 8'd7);
    wide_it.op       = i2cmbe_pkg::OP_START;
    wide_it.tx_byte  = 8'hC3;
    wide_it.send_ack = 1'b0;
    wide_it.sda_in   = 1'b1;
    send_tick(wide_it);
    repeat (12) random_tick();

    in_valid <= 1'b0;
    for (int i = 0; i < 2000 && sb.line_states_due.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.line_states_due.size() != 0) begin
      sb.errors++;
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               sb.line_states_due.size());
    end
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_front.sv
rtl/i2cmbe_queue.sv
rtl/i2cmbe_back.sv
rtl/i2c_master_byte_engine_unit.sv
bench/tb_i2c_byte_pkg.sv
bench/tb_i2c_master_byte_engine_unit.sv
